@@ hdl/murmur2_hash_stream_defines.svh @@
// assertion helpers used by the hash stream controller
`ifndef MURMUR2_HASH_STREAM_DEFINES_SVH
`define MURMUR2_HASH_STREAM_DEFINES_SVH

// same-cycle implication, checked outside reset
`define MH2_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("mh2 check failed");

// next-cycle implication, checked outside reset
`define MH2_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("mh2 check failed");

`endif

@@ hdl/mh2_pkg.sv @@
package mh2_pkg;

   // murmur2 mixing constants
   localparam logic [31:0] MH2_MUL     = 32'h5bd1e995;
   localparam int unsigned MH2_SHIFT_K = 24;
   localparam int unsigned MH2_SHIFT_A = 13;
   localparam int unsigned MH2_SHIFT_B = 15;

   // byte count of a full word
   localparam logic [2:0] MH2_FULL_COUNT = 3'd4;

   // commands from controller to datapath
   typedef struct packed {
      logic load;    // key beat accepted, start word mixing
      logic mix;     // second mixing step, update running hash
      logic finish;  // run avalanche, load result register
   } mh2_cmd_type;

endpackage

@@ hdl/murmur2_hash_stream.sv @@
// 32-bit murmur2 hash over a key streamed as little-endian words.
// req channel: one beat per key word. tuser marks the first beat of a key,
// whose key_length field starts the hash as seed xor length; tlast marks
// the final beat, which may hold 0 to 3 tail bytes (byte_count 5..7 act
// as 4). an empty key is one beat with first, last and byte_count 0.
// rsp channel: one beat with the finished hash per key, after the last beat.
// csr port: csr_we writes csr_wdata into the seed; write only while idle.
// beats: a key beat is accepted, then takes a mixing step, and no new beat
// is taken before that step; the h*m and k*m products run in parallel, the
// second k*m sits on a shared multiplier that also runs the avalanche step
// of a last beat, after which rsp_tvalid rises from the output register.
// stall: a finished hash waits in the output register while the next key
// beats are taken; a following last beat holds in the avalanche step
// until the waiting hash is taken.
// reset: seed and running hash clear to zero, output register empties.
module murmur2_hash_stream (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [31:0] csr_wdata,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [71:0] req_tdata,  // data_word[31:0], byte_count[34:32],
                                   // key_length[66:35], zero[71:67]
   input  logic        req_tuser,  // first
   input  logic        req_tlast,  // last
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata   // hash_value[31:0]
);
   import mh2_pkg::*;

   mh2_cmd_type cmd;

   mh2_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tlast  (req_tlast),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   mh2_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .cmd        (cmd),
      .data_word  (req_tdata[31:0]),
      .byte_count (req_tdata[34:32]),
      .key_length (req_tdata[66:35]),
      .first      (req_tuser),
      .hash_value (rsp_tdata)
   );

endmodule

@@ hdl/mh2_ctrl.sv @@
`include "murmur2_hash_stream_defines.svh"

module mh2_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   input  logic                 req_tlast,
   output logic                 req_tready,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output mh2_pkg::mh2_cmd_type cmd
);
   import mh2_pkg::*;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_MIX  = 2'd1;
   localparam logic [1:0] S_FIN  = 2'd2;

   logic [1:0] state_ff, state_in;
   logic       last_ff, last_in;
   logic       rsp_valid_ff, rsp_valid_in;

   // command decode
   always_comb begin
      req_tready = (state_ff == S_IDLE);
      cmd.load   = req_tvalid && req_tready;
      cmd.mix    = (state_ff == S_MIX);
      cmd.finish = (state_ff == S_FIN) && (!rsp_valid_ff || rsp_tready);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (cmd.load) state_in = S_MIX;
         end
         S_MIX: begin
            state_in = last_ff ? S_FIN : S_IDLE;
         end
         S_FIN: begin
            if (cmd.finish) state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // last flag of the beat in flight
   assign last_in = cmd.load ? req_tlast : last_ff;

   // output register valid
   always_comb begin
      if (cmd.finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         last_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         last_ff      <= last_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // checks
   `MH2_ASSERT_NEXT(a_load_to_mix, clock, reset, cmd.load, state_ff == S_MIX)
   `MH2_ASSERT_NEXT(a_last_to_fin, clock, reset, cmd.mix && last_ff, state_ff == S_FIN)
   `MH2_ASSERT_NOW(a_no_overwrite, clock, reset, cmd.finish, !rsp_valid_ff || rsp_tready)
   `MH2_ASSERT_NEXT(a_fin_fills, clock, reset, (state_ff == S_FIN) && !rsp_valid_ff,
                    rsp_valid_ff && (state_ff == S_IDLE))

endmodule

@@ hdl/mh2_datapath.sv @@
module mh2_datapath (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_we,
   input  logic [31:0]          csr_wdata,
   input  mh2_pkg::mh2_cmd_type cmd,
   input  logic [31:0]          data_word,
   input  logic [2:0]           byte_count,
   input  logic [31:0]          key_length,
   input  logic                 first,
   output logic [31:0]          hash_value
);
   import mh2_pkg::*;

   logic [31:0] seed_ff, seed_in;
   logic [31:0] hash_ff, hash_in;
   logic [31:0] prod_a_ff, prod_a_in;
   logic [31:0] prod_b_ff, prod_b_in;
   logic        full_ff, full_in;
   logic [31:0] rsp_data_ff, rsp_data_in;

   logic [31:0] start_hash;
   logic        full_word;
   logic [31:0] tail_mask;
   logic [31:0] mul_a_op, mul_a, mul_b;
   logic [31:0] k_shuf, aval_op, mul_c_op, mul_c;

   // seed register
   assign seed_in = csr_we ? csr_wdata : seed_ff;

   // first stage: start hash, tail fold or k times m, and h times m
   always_comb begin
      start_hash = first ? (seed_ff ^ key_length) : hash_ff;
      full_word  = (byte_count >= MH2_FULL_COUNT);
      unique case (byte_count)
         3'd1:    tail_mask = 32'h0000_00ff;
         3'd2:    tail_mask = 32'h0000_ffff;
         3'd3:    tail_mask = 32'h00ff_ffff;
         default: tail_mask = 32'h0000_0000;
      endcase
      mul_a_op = full_word ? data_word : (start_hash ^ (data_word & tail_mask));
      mul_a    = mul_a_op * MH2_MUL;
      mul_b    = start_hash * MH2_MUL;
   end

   // register the products on load; an empty tail leaves the hash unchanged
   always_comb begin
      full_in   = cmd.load ? full_word : full_ff;
      prod_a_in = prod_a_ff;
      prod_b_in = prod_b_ff;
      if (cmd.load) begin
         prod_a_in = (!full_word && (byte_count == 3'd0)) ? start_hash : mul_a;
         prod_b_in = mul_b;
      end
   end

   // shared second multiplier: k mixing or avalanche
   always_comb begin
      k_shuf   = prod_a_ff ^ (prod_a_ff >> MH2_SHIFT_K);
      aval_op  = hash_ff ^ (hash_ff >> MH2_SHIFT_A);
      mul_c_op = cmd.mix ? k_shuf : aval_op;
      mul_c    = mul_c_op * MH2_MUL;
   end

   // running hash and result register
   always_comb begin
      hash_in = hash_ff;
      if (cmd.mix) begin
         hash_in = full_ff ? (prod_b_ff ^ mul_c) : prod_a_ff;
      end
      rsp_data_in = cmd.finish ? (mul_c ^ (mul_c >> MH2_SHIFT_B)) : rsp_data_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff <= 32'h0;
         hash_ff <= 32'h0;
      end else begin
         seed_ff <= seed_in;
         hash_ff <= hash_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_a_ff   <= prod_a_in;
      prod_b_ff   <= prod_b_in;
      full_ff     <= full_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign hash_value = rsp_data_ff;

endmodule

@@ sim/murmur2_hash_checker.sv @@
`timescale 1ns / 1ps

module murmur2_hash_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_we,
   input  logic [31:0]        csr_wdata,
   input  logic               req_tvalid,
   input  logic               req_tready,
   input  logic [71:0]        req_tdata,  // data_word[31:0], byte_count[34:32],
                                          // key_length[66:35], zero[71:67]
   input  logic               req_tuser,  // first
   input  logic               req_tlast,  // last
   input  logic               rsp_tvalid,
   input  logic               rsp_tready,
   input  logic [31:0]        rsp_tdata,  // hash_value[31:0]
   output int unsigned        mismatch_count,
   output int unsigned        pending_hashes,
   output int unsigned        hashes_checked
);

   localparam logic [31:0] MURMUR_M = 32'h5bd1e995;
   localparam int unsigned WORD_SHIFT = 24;
   localparam int unsigned FINAL_SHIFT_1 = 13;
   localparam int unsigned FINAL_SHIFT_2 = 15;

   logic [31:0] seed_q;
   logic [31:0] chain_hash;
   logic [31:0] next_hash;
   logic [2:0]  beat_bytes;
   logic [31:0] expected_hashes[$];
   logic [31:0] oldest_hash;

   // full four-byte word mixed into the running hash
   function automatic logic [31:0] mix_full_word(input logic [31:0] h, input logic [31:0] k);
      logic [31:0] kk;
      kk = k * MURMUR_M;
      kk = kk ^ (kk >> WORD_SHIFT);
      kk = kk * MURMUR_M;
      return (h * MURMUR_M) ^ kk;
   endfunction

   // one to three trailing bytes folded in with a single multiply
   function automatic logic [31:0] fold_tail_bytes(input logic [31:0] h,
                                                   input logic [31:0] word,
                                                   input logic [2:0]  nbytes);
      logic [31:0] mask;
      case (nbytes)
         3'd1: mask = 32'h0000_00ff;
         3'd2: mask = 32'h0000_ffff;
         3'd3: mask = 32'h00ff_ffff;
         default: mask = 32'h0;
      endcase
      if (nbytes == 3'd0)
         return h;
      return (h ^ (word & mask)) * MURMUR_M;
   endfunction

   // final avalanche of the finished key
   function automatic logic [31:0] finish_hash(input logic [31:0] h);
      logic [31:0] x;
      x = h ^ (h >> FINAL_SHIFT_1);
      x = x * MURMUR_M;
      return x ^ (x >> FINAL_SHIFT_2);
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch at %0t: %s got %08h expected %08h", $time, what, got, want);
      mismatch_count++;
   endtask

   // track seed and running hash, queue hashes, compare result beats
   always @(posedge clock) begin
      if (reset) begin
         seed_q = 32'h0;
         chain_hash = 32'h0;
         expected_hashes.delete();
      end else begin
         if (csr_we)
            seed_q = csr_wdata;
         if (req_tvalid && req_tready) begin
            beat_bytes = req_tdata[34:32];
            if (beat_bytes > 3'd4)
               beat_bytes = 3'd4;
            next_hash = req_tuser ? (seed_q ^ req_tdata[66:35]) : chain_hash;
            if (beat_bytes == 3'd4)
               next_hash = mix_full_word(next_hash, req_tdata[31:0]);
            else
               next_hash = fold_tail_bytes(next_hash, req_tdata[31:0], beat_bytes);
            chain_hash = next_hash;
            if (req_tlast)
               expected_hashes.push_back(finish_hash(next_hash));
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_hashes.size() == 0) begin
               report_mismatch("hash beat with none pending,", rsp_tdata, 32'h0);
            end else begin
               oldest_hash = expected_hashes.pop_front();
               hashes_checked++;
               if (rsp_tdata !== oldest_hash)
                  report_mismatch("hash_value", rsp_tdata, oldest_hash);
            end
         end
      end
      pending_hashes = expected_hashes.size();
   end

endmodule

@@ sim/murmur2_hash_stream_tb.sv @@
`timescale 1ns / 1ps

module murmur2_hash_stream_tb;
   import mh2_pkg::*;

   localparam int unsigned TOTAL_BEATS = 1650;
   localparam int unsigned QUIET_BEATS = 200;
   localparam int unsigned SETTLE_CYCLES = 8;
   localparam int unsigned CYCLE_LIMIT = 500000;

   logic        clock;
   logic        reset;
   logic        csr_we;
   logic [31:0] csr_wdata;
   logic        req_tvalid;
   logic        req_tready;
   logic [71:0] req_tdata;  // data_word[31:0], byte_count[34:32],
                            // key_length[66:35], zero[71:67]
   logic        req_tuser;  // first
   logic        req_tlast;  // last
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;  // hash_value[31:0]

   int unsigned mismatch_count;
   int unsigned pending_hashes;
   int unsigned hashes_checked;

   int unsigned idle_odds = 0;
   int unsigned stall_left = 0;
   int unsigned cycle_count = 0;
   int unsigned beats_sent = 0;
   int unsigned keys_sent = 0;
   int unsigned seeds_written = 0;

   murmur2_hash_stream i_dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   murmur2_hash_checker i_checker (
      .clock          (clock),
      .reset          (reset),
      .csr_we         (csr_we),
      .csr_wdata      (csr_wdata),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .req_tlast      (req_tlast),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .mismatch_count (mismatch_count),
      .pending_hashes (pending_hashes),
      .hashes_checked (hashes_checked)
   );

   // 2 ns clock
   always begin
      clock = 1'b1;
      #1;
      clock = 1'b0;
      #1;
   end

   // run watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // hash receiver with random stall bursts
   always @(negedge clock) begin
      if (stall_left != 0) begin
         rsp_tready <= 1'b0;
         stall_left <= stall_left - 1;
      end else if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
         rsp_tready <= 1'b0;
         stall_left <= $urandom_range(0, 9);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // key words with occasional all-zero or all-one content
   function automatic logic [31:0] pick_word();
      case ($urandom_range(0, 7))
         0: return 32'h0000_0000;
         1: return 32'hffff_ffff;
         default: return $urandom;
      endcase
   endfunction

   // one key beat, leaves tvalid high after the handshake
   task automatic send_beat(input logic [31:0] word, input logic [2:0] nbytes,
                            input logic [31:0] klen, input logic is_first,
                            input logic is_last);
      int unsigned gap;
      gap = 0;
      if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1)
         gap = $urandom_range(1, 10);
      if (gap != 0) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata <= {5'b0, klen, nbytes, word};
      req_tuser <= is_first;
      req_tlast <= is_last;
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      beats_sent++;
   endtask

   // whole key split into beats; first or last flag may be dropped
   task automatic send_key(input int unsigned nbytes, input logic [31:0] klen,
                           input bit drop_first, input bit drop_last);
      int unsigned full_words;
      int unsigned tail;
      int unsigned nbeats;
      int unsigned idx;
      logic [2:0]  cnt;
      full_words = nbytes / 4;
      tail = nbytes % 4;
      nbeats = full_words + ((tail != 0 || nbytes == 0) ? 1 : 0);
      for (idx = 0; idx < nbeats; idx++) begin
         if (idx < full_words)
            cnt = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(5, 7)) : MH2_FULL_COUNT;
         else
            cnt = 3'(tail);
         send_beat(pick_word(), cnt, klen, (idx == 0) && !drop_first,
                   (idx == nbeats - 1) && !drop_last);
      end
      keys_sent++;
   endtask

   // stop sending and wait until every hash has come back
   task automatic drain();
      @(negedge clock);
      req_tvalid <= 1'b0;
      do
         @(negedge clock);
      while (pending_hashes != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_seed(input logic [31:0] value);
      drain();
      @(negedge clock);
      csr_we <= 1'b1;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
      seeds_written++;
   endtask

   initial begin
      logic [31:0] phase_seeds[5];
      int unsigned phase_odds[5];
      int unsigned phase;
      int unsigned phase_end;
      int unsigned pick;
      int unsigned nbytes;
      int unsigned idx;

      reset = 1'b1;
      csr_we = 1'b0;
      csr_wdata = 32'h0;
      req_tvalid = 1'b0;
      req_tdata = 72'h0;
      req_tuser = 1'b0;
      req_tlast = 1'b0;
      repeat (8) @(negedge clock);
      reset <= 1'b0;

      // directed: continuation straight after reset runs from a zero hash
      idle_odds = 4;
      send_beat(32'h1234_5678, MH2_FULL_COUNT, 32'hdead_beef, 1'b0, 1'b1);
      send_beat(32'hcafe_f00d, 3'd2, 32'h0, 1'b0, 1'b0);
      send_beat(32'h0bad_cafe, MH2_FULL_COUNT, 32'h0, 1'b0, 1'b1);
      // empty keys at both length extremes
      send_beat(32'hffff_ffff, 3'd0, 32'h0, 1'b1, 1'b1);
      send_beat(32'h0000_0000, 3'd0, 32'hffff_ffff, 1'b1, 1'b1);
      // single tail of one to three bytes, upper bytes must be masked
      for (idx = 1; idx <= 3; idx++)
         send_beat(32'hffff_ffff, 3'(idx), idx, 1'b1, 1'b1);
      send_beat(32'hffff_ffff, MH2_FULL_COUNT, 32'd4, 1'b1, 1'b1);
      // oversized byte counts act as full words
      send_beat(32'hffff_ffff, 3'd5, 32'd12, 1'b1, 1'b0);
      send_beat(32'h0000_0000, 3'd6, 32'd12, 1'b0, 1'b0);
      send_beat(32'h8000_0001, 3'd7, 32'd12, 1'b0, 1'b1);
      // partial word in the middle of a key
      send_beat(32'h0102_0304, 3'd3, 32'd8, 1'b1, 1'b0);
      send_beat(32'h0506_0708, MH2_FULL_COUNT, 32'd8, 1'b0, 1'b1);
      // abandoned key, then a restart with first
      send_beat(32'h5555_aaaa, MH2_FULL_COUNT, 32'd100, 1'b1, 1'b0);
      send_beat(32'haaaa_5555, 3'd2, 32'd2, 1'b1, 1'b1);
      // zero bytes on a beat that is not last
      send_beat(32'h7777_7777, 3'd0, 32'h0000_0001, 1'b1, 1'b0);
      send_beat(32'h0000_00ff, 3'd1, 32'h0000_0001, 1'b0, 1'b1);
      // length field that disagrees with the bytes sent
      send_beat(32'hffff_ffff, MH2_FULL_COUNT, 32'hffff_ffff, 1'b1, 1'b1);
      send_beat(32'h0000_0000, MH2_FULL_COUNT, 32'h8000_0000, 1'b1, 1'b1);
      send_key(7, 32'd7, 1'b0, 1'b0);

      // random keys under several seeds, extremes first
      phase_seeds[0] = 32'hffff_ffff;
      phase_seeds[1] = 32'h0000_0000;
      phase_seeds[2] = 32'h8000_0000;
      phase_seeds[3] = $urandom;
      phase_seeds[4] = $urandom;
      phase_odds[0] = 4;
      phase_odds[1] = 0;
      phase_odds[2] = 3;
      phase_odds[3] = 6;
      phase_odds[4] = 5;
      for (phase = 0; phase < 5; phase++) begin
         write_seed(phase_seeds[phase]);
         idle_odds = phase_odds[phase];
         send_beat(32'h0, 3'd0, 32'h0, 1'b1, 1'b1);
         phase_end = beats_sent + (TOTAL_BEATS - beats_sent) / (5 - phase);
         while (beats_sent < phase_end) begin
            if (beats_sent + QUIET_BEATS >= TOTAL_BEATS)
               idle_odds = 0;
            pick = $urandom_range(0, 99);
            nbytes = (pick % 8 == 0) ? $urandom_range(25, 64) : $urandom_range(0, 24);
            if (pick < 70)
               send_key(nbytes, nbytes, 1'b0, 1'b0);
            else if (pick < 82)
               send_key(nbytes, $urandom, 1'b0, 1'b0);
            else if (pick < 92)
               send_beat($urandom, 3'($urandom_range(0, 7)), $urandom,
                         1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            else if (pick < 96)
               send_key(nbytes, nbytes, 1'b1, 1'b0);
            else
               send_key(nbytes, nbytes, 1'b0, 1'b1);
         end
      end

      drain();
      repeat (SETTLE_CYCLES) @(negedge clock);
      $display("sent %0d keys in %0d beats under %0d seed values plus the reset seed",
               keys_sent, beats_sent, seeds_written);
      $display("compared %0d hashes, including empty, tail, oversized and broken keys",
               hashes_checked);
      if (mismatch_count == 0 && pending_hashes == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
